// File: rtl/core/pmm_pkg.sv
// Shared types, constants and datapath command codes for the paged memory manager.
package pmm_pkg;

    localparam int OFFSET_BITS_DEF   = 10;
    localparam int FRAME_COUNT_DEF   = 1024;
    localparam int ADDRESS_BITS_DEF  = 20;
    localparam int PROCESS_COUNT_DEF = 16;

    localparam int KIND_W  = 2;
    localparam int PID_W   = 4;
    localparam int VADDR_W = 20;
    localparam int SIZE_W  = 21;
    localparam int DATA_W  = 8;
    localparam int CFG_W   = 20;

    localparam logic [CFG_W-1:0] INIT_BREAK = CFG_W'(1024);

    localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [PID_W-1:0]   pid;
        logic [VADDR_W-1:0] vaddr;
        logic [SIZE_W-1:0]  size_bytes;
        logic [DATA_W-1:0]  write_data;
    } req_t;

    typedef struct packed {
        logic               status;
        logic [VADDR_W-1:0] alloc_addr;
        logic [DATA_W-1:0]  read_data;
    } rsp_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LATCH,
        OP_MAP_RD,
        OP_FRAME_RD,
        OP_CNT_FREE,
        OP_SCAN_INIT,
        OP_TAKE,
        OP_CHAIN_END,
        OP_FREE_START,
        OP_WALK_REL,
        OP_UNMAP_INIT,
        OP_UNMAP,
        OP_BRK_RD,
        OP_BRK_DEC,
        OP_BRK_STORE,
        OP_BYTE_ACC,
        OP_RESP_FAIL,
        OP_RESP_OK,
        OP_RESP_READ
    } dp_op_t;

    typedef struct packed {
        logic clearing;
        logic pid_ok;
        logic is_alloc;
        logic is_free;
        logic is_read;
        logic size_zero;
        logic vp_oob;
        logic map_hit;
        logic avail_enough;
        logic scan_end;
        logic fit;
        logic walk_ok;
        logic unmap_more;
        logic brk_match;
        logic brk_ge_page;
        logic brk_hit;
    } dp_stat_t;

    function automatic logic is_resp_op(input dp_op_t op);
        begin
            return (op == OP_RESP_FAIL) || (op == OP_RESP_OK) || (op == OP_RESP_READ) ||
                   (op == OP_CHAIN_END) || (op == OP_BRK_STORE);
        end
    endfunction

endpackage

// File: rtl/core/pmm_if.sv
// Request and response channel interfaces.
interface pmm_req_if;
    import pmm_pkg::*;
    logic valid;
    logic ready;
    req_t data;
    modport src (output valid, output data, input ready);
    modport snk (input valid, input data, output ready);
endinterface

interface pmm_rsp_if;
    import pmm_pkg::*;
    logic valid;
    logic ready;
    rsp_t data;
    modport src (output valid, output data, input ready);
    modport snk (input valid, input data, output ready);
endinterface

// File: rtl/core/pmm_dp.sv
// Datapath: frame, map and byte memories, break registers, scan counters, result register.
module pmm_dp #(
    parameter int OFFSET_BITS   = pmm_pkg::OFFSET_BITS_DEF,
    parameter int FRAME_COUNT   = pmm_pkg::FRAME_COUNT_DEF,
    parameter int ADDRESS_BITS  = pmm_pkg::ADDRESS_BITS_DEF,
    parameter int PROCESS_COUNT = pmm_pkg::PROCESS_COUNT_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  pmm_pkg::dp_op_t            op,
    input  pmm_pkg::req_t              req_data,
    input  logic                       cfg_wr_en,
    input  logic [pmm_pkg::CFG_W-1:0]  cfg_wr_data,
    output pmm_pkg::dp_stat_t          stat,
    output pmm_pkg::rsp_t              rsp_data
);
    import pmm_pkg::*;

    localparam int FB       = $clog2(FRAME_COUNT);
    localparam int FI_W     = FB + 1;
    localparam int VP_BITS  = ADDRESS_BITS - OFFSET_BITS;
    localparam int PID_BITS = $clog2(PROCESS_COUNT);
    localparam int MAP_AW   = PID_BITS + VP_BITS;
    localparam int ST_AW    = FB + OFFSET_BITS;
    localparam longint unsigned MAP_D   = 64'd1 << MAP_AW;
    localparam longint unsigned STORE_D = longint'(FRAME_COUNT) << OFFSET_BITS;
    localparam longint unsigned CLR_A   = (MAP_D > STORE_D) ? MAP_D : STORE_D;
    localparam longint unsigned CLR_N   = (CLR_A > FRAME_COUNT) ? CLR_A : FRAME_COUNT;
    localparam int CLR_W    = $clog2(CLR_N) + 1;
    localparam int BP_W     = (ADDRESS_BITS > CFG_W) ? ADDRESS_BITS : CFG_W;
    localparam int N_W      = SIZE_W + 1 - OFFSET_BITS;
    localparam int CNT_W    = (N_W > FI_W) ? N_W : FI_W;
    localparam int SUM_A    = (ADDRESS_BITS > BP_W) ? ADDRESS_BITS : BP_W;
    localparam int SUM_W    = ((SUM_A > SIZE_W + 1) ? SUM_A : SIZE_W + 1) + 2;
    localparam int UP_W     = ((VADDR_W > FI_W) ? VADDR_W : FI_W) + 1;

    localparam logic [FI_W-1:0]  CHAIN_END = FI_W'(FRAME_COUNT);
    localparam logic [BP_W-1:0]  PAGE_B    = BP_W'(1) << OFFSET_BITS;
    localparam logic [SUM_W-1:0] PAGE_S    = SUM_W'(1) << OFFSET_BITS;
    localparam logic [SUM_W-1:0] SPACE_S   = SUM_W'(1) << ADDRESS_BITS;

    logic [PID_BITS-1:0] owner_mem [FRAME_COUNT];
    logic [FI_W-1:0]     next_mem  [FRAME_COUNT];
    logic [FB:0]         map_mem   [0:MAP_D-1];
    logic [DATA_W-1:0]   byte_mem  [0:STORE_D-1];

    req_t                req_reg;
    logic [BP_W-1:0]     bp_reg;
    logic [FI_W-1:0]     idx_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [FI_W-1:0]     last_reg;
    logic [PID_BITS-1:0] owner_rd_reg;
    logic [FI_W-1:0]     next_rd_reg;
    logic [FB:0]         map_rd_reg;
    logic [DATA_W-1:0]   byte_rd_reg;
    rsp_t                rsp_reg;
    logic [CLR_W-1:0]    clr_reg;
    logic [BP_W-1:0]     brk_reg [PROCESS_COUNT];

    logic [PID_BITS-1:0] pid_idx;
    logic [PID_BITS-1:0] pid_in_idx;
    logic                clearing;
    logic [N_W-1:0]      n_pages;
    logic [SUM_W-1:0]    alloc_end;
    logic [VP_BITS-1:0]  req_page;
    logic [VP_BITS-1:0]  alloc_page;
    logic [UP_W-1:0]     unmap_page;
    logic [BP_W-1:0]     low_page;
    logic                owner_free;
    logic                take;

    logic                own_we;
    logic [FB-1:0]       own_wa;
    logic [PID_BITS-1:0] own_wd;
    logic                next_we;
    logic [FB-1:0]       next_wa;
    logic [FI_W-1:0]     next_wd;
    logic                map_we;
    logic [MAP_AW-1:0]   map_wa;
    logic [FB:0]         map_wd;
    logic                map_re;
    logic [MAP_AW-1:0]   map_ra;
    logic                byte_we;
    logic [ST_AW-1:0]    byte_wa;
    logic [DATA_W-1:0]   byte_wd;
    logic [ST_AW-1:0]    byte_addr;

    assign pid_idx    = PID_BITS'(req_reg.pid);
    assign pid_in_idx = PID_BITS'(req_data.pid);
    assign clearing   = (clr_reg != CLR_W'(CLR_N));
    assign n_pages    = N_W'((SUM_W'(req_reg.size_bytes) + PAGE_S - SUM_W'(1)) >> OFFSET_BITS);
    assign alloc_end  = SUM_W'(bp_reg) + (SUM_W'(n_pages) << OFFSET_BITS);
    assign req_page   = VP_BITS'(req_reg.vaddr >> OFFSET_BITS);
    assign alloc_page = VP_BITS'(bp_reg >> OFFSET_BITS) + VP_BITS'(cnt_reg);
    assign unmap_page = UP_W'(req_reg.vaddr >> OFFSET_BITS) + UP_W'(idx_reg);
    assign low_page   = (bp_reg - PAGE_B) >> OFFSET_BITS;
    assign owner_free = (owner_rd_reg == '0);
    assign take       = (op == OP_TAKE) && owner_free;
    assign byte_addr  = {map_rd_reg[FB-1:0], req_reg.vaddr[OFFSET_BITS-1:0]};

    // status to the controller
    always_comb
    begin
        stat.clearing     = clearing;
        stat.pid_ok       = (req_reg.pid != '0) && (32'(req_reg.pid) < PROCESS_COUNT);
        stat.is_alloc     = (req_reg.kind == KIND_ALLOC);
        stat.is_free      = (req_reg.kind == KIND_FREE);
        stat.is_read      = (req_reg.kind == KIND_READ);
        stat.size_zero    = (req_reg.size_bytes == '0);
        stat.vp_oob       = ((req_reg.vaddr >> ADDRESS_BITS) != '0);
        stat.map_hit      = map_rd_reg[FB] && (FI_W'(map_rd_reg[FB-1:0]) < CHAIN_END);
        stat.avail_enough = (cnt_reg == CNT_W'(n_pages));
        stat.scan_end     = (idx_reg == CHAIN_END);
        stat.fit          = (alloc_end < SPACE_S);
        stat.walk_ok      = (idx_reg < CHAIN_END) && (owner_rd_reg == pid_idx) &&
                            (cnt_reg < CNT_W'(FRAME_COUNT));
        stat.unmap_more   = (CNT_W'(idx_reg) < cnt_reg) && ((unmap_page >> VP_BITS) == '0);
        stat.brk_match    = (SUM_W'(req_reg.vaddr) + (SUM_W'(cnt_reg) << OFFSET_BITS))
                            == SUM_W'(bp_reg);
        stat.brk_ge_page  = (bp_reg >= PAGE_B);
        stat.brk_hit      = ((low_page >> VP_BITS) == '0) && map_rd_reg[FB];
    end

    // memory write and read ports
    always_comb
    begin
        own_we  = 1'b0;
        own_wa  = idx_reg[FB-1:0];
        own_wd  = '0;
        next_we = 1'b0;
        next_wa = last_reg[FB-1:0];
        next_wd = idx_reg;
        map_we  = 1'b0;
        map_wa  = {pid_idx, alloc_page};
        map_wd  = {1'b1, idx_reg[FB-1:0]};
        byte_we = 1'b0;
        byte_wa = byte_addr;
        byte_wd = req_reg.write_data;
        map_re  = (op == OP_MAP_RD) || (op == OP_BRK_RD);
        map_ra  = (op == OP_BRK_RD) ? {pid_idx, VP_BITS'(low_page)} : {pid_idx, req_page};
        if (clearing)
        begin
            own_we  = (clr_reg < CLR_W'(FRAME_COUNT));
            own_wa  = FB'(clr_reg);
            map_we  = (clr_reg < CLR_W'(MAP_D));
            map_wa  = MAP_AW'(clr_reg);
            map_wd  = '0;
            byte_we = (clr_reg < CLR_W'(STORE_D));
            byte_wa = ST_AW'(clr_reg);
            byte_wd = '0;
        end
        else
        begin
            if (take)
            begin
                own_we  = 1'b1;
                own_wd  = pid_idx;
                next_we = (last_reg != CHAIN_END);
                map_we  = 1'b1;
            end
            if (op == OP_WALK_REL)
                own_we = 1'b1;
            if (op == OP_CHAIN_END)
            begin
                next_we = 1'b1;
                next_wd = CHAIN_END;
            end
            if (op == OP_UNMAP)
            begin
                map_we = 1'b1;
                map_wa = {pid_idx, VP_BITS'(unmap_page)};
                map_wd = '0;
            end
            if ((op == OP_BYTE_ACC) && (req_reg.kind == KIND_WRITE))
                byte_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (own_we)
            owner_mem[own_wa] <= own_wd;
        if (op == OP_FRAME_RD)
            owner_rd_reg <= owner_mem[idx_reg[FB-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (next_we)
            next_mem[next_wa] <= next_wd;
        if (op == OP_FRAME_RD)
            next_rd_reg <= next_mem[idx_reg[FB-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (map_we)
            map_mem[map_wa] <= map_wd;
        if (map_re)
            map_rd_reg <= map_mem[map_ra];
    end

    always_ff @(posedge clk)
    begin
        if (byte_we)
            byte_mem[byte_wa] <= byte_wd;
        if (op == OP_BYTE_ACC)
            byte_rd_reg <= byte_mem[byte_addr];
    end

    // working registers
    always_ff @(posedge clk)
    begin
        case (op)
            OP_LATCH:
            begin
                req_reg  <= req_data;
                bp_reg   <= brk_reg[pid_in_idx];
                idx_reg  <= '0;
                cnt_reg  <= '0;
                last_reg <= CHAIN_END;
            end
            OP_SCAN_INIT:
            begin
                idx_reg  <= '0;
                cnt_reg  <= '0;
                last_reg <= CHAIN_END;
            end
            OP_CNT_FREE:
            begin
                if (owner_free)
                    cnt_reg <= cnt_reg + CNT_W'(1);
                idx_reg <= idx_reg + FI_W'(1);
            end
            OP_TAKE:
            begin
                if (owner_free)
                begin
                    cnt_reg  <= cnt_reg + CNT_W'(1);
                    last_reg <= idx_reg;
                end
                idx_reg <= idx_reg + FI_W'(1);
            end
            OP_FREE_START:
            begin
                idx_reg <= FI_W'(map_rd_reg[FB-1:0]);
                cnt_reg <= '0;
            end
            OP_WALK_REL:
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                idx_reg <= next_rd_reg;
            end
            OP_UNMAP_INIT: idx_reg <= '0;
            OP_UNMAP:      idx_reg <= idx_reg + FI_W'(1);
            OP_BRK_DEC:    bp_reg  <= bp_reg - PAGE_B;
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge clk)
    begin
        case (op)
            OP_RESP_FAIL: rsp_reg <= '{status: 1'b1, alloc_addr: '0, read_data: '0};
            OP_RESP_OK,
            OP_BRK_STORE: rsp_reg <= '{status: 1'b0, alloc_addr: '0, read_data: '0};
            OP_CHAIN_END: rsp_reg <= '{status: 1'b0, alloc_addr: VADDR_W'(bp_reg),
                                       read_data: '0};
            OP_RESP_READ: rsp_reg <= '{status: 1'b0, alloc_addr: '0, read_data: byte_rd_reg};
            default: ;
        endcase
    end

    assign rsp_data = rsp_reg;

    // clearing sweep and per-process break pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
            for (int p = 0; p < PROCESS_COUNT; p++)
                brk_reg[p] <= BP_W'(INIT_BREAK);
        end
        else
        begin
            if (clearing)
                clr_reg <= clr_reg + CLR_W'(1);
            if (cfg_wr_en)
            begin
                for (int p = 0; p < PROCESS_COUNT; p++)
                    brk_reg[p] <= BP_W'(cfg_wr_data);
            end
            else if (op == OP_CHAIN_END)
                brk_reg[pid_idx] <= BP_W'(alloc_end);
            else if (op == OP_BRK_STORE)
                brk_reg[pid_idx] <= bp_reg;
        end
    end

endmodule

// File: rtl/core/pmm_ctrl.sv
// Controller state machine: sequences the datapath for each request kind.
module pmm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  pmm_pkg::dp_stat_t stat,
    output pmm_pkg::dp_op_t   op
);
    import pmm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_LOOKUP,
        S_ACC,
        S_A_CNT_RD,
        S_A_CNT_CHK,
        S_A_FIT,
        S_A_TK_RD,
        S_A_TK_CHK,
        S_W_RD,
        S_W_CHK,
        S_U_STEP,
        S_B_CHK,
        S_B_LOOP,
        S_B_TEST
    } state_t;

    state_t state_reg;
    state_t state_next;
    state_t state_pre;
    dp_op_t op_pre;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign in_ready  = (state_reg == S_IDLE) && !stat.clearing;
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_pre = state_reg;
        op_pre    = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    op_pre    = OP_LATCH;
                    state_pre = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (!stat.pid_ok)
                begin
                    op_pre    = OP_RESP_FAIL;
                    state_pre = S_IDLE;
                end
                else if (stat.is_alloc)
                begin
                    if (stat.size_zero)
                    begin
                        op_pre    = OP_RESP_FAIL;
                        state_pre = S_IDLE;
                    end
                    else
                        state_pre = S_A_CNT_RD;
                end
                else if (stat.vp_oob)
                begin
                    op_pre    = OP_RESP_FAIL;
                    state_pre = S_IDLE;
                end
                else
                begin
                    op_pre    = OP_MAP_RD;
                    state_pre = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                if (!stat.map_hit)
                begin
                    op_pre    = OP_RESP_FAIL;
                    state_pre = S_IDLE;
                end
                else if (stat.is_free)
                begin
                    op_pre    = OP_FREE_START;
                    state_pre = S_W_RD;
                end
                else
                begin
                    op_pre    = OP_BYTE_ACC;
                    state_pre = S_ACC;
                end
            end
            S_ACC:
            begin
                op_pre    = stat.is_read ? OP_RESP_READ : OP_RESP_OK;
                state_pre = S_IDLE;
            end
            S_A_CNT_RD:
            begin
                if (stat.avail_enough)
                    state_pre = S_A_FIT;
                else if (stat.scan_end)
                begin
                    op_pre    = OP_RESP_FAIL;
                    state_pre = S_IDLE;
                end
                else
                begin
                    op_pre    = OP_FRAME_RD;
                    state_pre = S_A_CNT_CHK;
                end
            end
            S_A_CNT_CHK:
            begin
                op_pre    = OP_CNT_FREE;
                state_pre = S_A_CNT_RD;
            end
            S_A_FIT:
            begin
                if (stat.fit)
                begin
                    op_pre    = OP_SCAN_INIT;
                    state_pre = S_A_TK_RD;
                end
                else
                begin
                    op_pre    = OP_RESP_FAIL;
                    state_pre = S_IDLE;
                end
            end
            S_A_TK_RD:
            begin
                if (stat.avail_enough)
                begin
                    op_pre    = OP_CHAIN_END;
                    state_pre = S_IDLE;
                end
                else
                begin
                    op_pre    = OP_FRAME_RD;
                    state_pre = S_A_TK_CHK;
                end
            end
            S_A_TK_CHK:
            begin
                op_pre    = OP_TAKE;
                state_pre = S_A_TK_RD;
            end
            S_W_RD:
            begin
                op_pre    = OP_FRAME_RD;
                state_pre = S_W_CHK;
            end
            S_W_CHK:
            begin
                if (stat.walk_ok)
                begin
                    op_pre    = OP_WALK_REL;
                    state_pre = S_W_RD;
                end
                else
                begin
                    op_pre    = OP_UNMAP_INIT;
                    state_pre = S_U_STEP;
                end
            end
            S_U_STEP:
            begin
                if (stat.unmap_more)
                    op_pre = OP_UNMAP;
                else
                    state_pre = S_B_CHK;
            end
            S_B_CHK:
            begin
                if (stat.brk_match)
                    state_pre = S_B_LOOP;
                else
                begin
                    op_pre    = OP_RESP_OK;
                    state_pre = S_IDLE;
                end
            end
            S_B_LOOP:
            begin
                if (stat.brk_ge_page)
                begin
                    op_pre    = OP_BRK_RD;
                    state_pre = S_B_TEST;
                end
                else
                begin
                    op_pre    = OP_BRK_STORE;
                    state_pre = S_IDLE;
                end
            end
            S_B_TEST:
            begin
                if (stat.brk_hit)
                begin
                    op_pre    = OP_BRK_STORE;
                    state_pre = S_IDLE;
                end
                else
                begin
                    op_pre    = OP_BRK_DEC;
                    state_pre = S_B_LOOP;
                end
            end
            default: state_pre = S_IDLE;
        endcase
    end

    // hold the finishing step until the result register is free
    always_comb
    begin
        op         = op_pre;
        state_next = state_pre;
        if (is_resp_op(op_pre) && !out_free)
        begin
            op         = OP_NONE;
            state_next = state_reg;
        end
        out_valid_next = is_resp_op(op) ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: rtl/core/paged_memory_manager.sv
// Paged memory manager top level: controller, datapath and channel ports.
// Read and write: latch the request, look up the map, access the byte, then give the result.
// Allocate: a free-count scan over the frames, then a take scan that claims free frames.
// Free: walk the chain releasing frames, unmap the pages, then lower the break if it ended there.
// One item in flight; the result register lets the next item enter while a result waits.
// After reset a sweep zeroes the owner, map and byte memories; no item is accepted until it ends.
module paged_memory_manager #(
    parameter int OFFSET_BITS   = pmm_pkg::OFFSET_BITS_DEF,
    parameter int FRAME_COUNT   = pmm_pkg::FRAME_COUNT_DEF,
    parameter int ADDRESS_BITS  = pmm_pkg::ADDRESS_BITS_DEF,
    parameter int PROCESS_COUNT = pmm_pkg::PROCESS_COUNT_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [pmm_pkg::CFG_W-1:0] cfg_wr_data,
    pmm_req_if.snk                    req,
    pmm_rsp_if.src                    rsp
);
    import pmm_pkg::*;

    dp_op_t   op;
    dp_stat_t stat;

    pmm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .op        (op)
    );

    pmm_dp #(
        .OFFSET_BITS   (OFFSET_BITS),
        .FRAME_COUNT   (FRAME_COUNT),
        .ADDRESS_BITS  (ADDRESS_BITS),
        .PROCESS_COUNT (PROCESS_COUNT)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (op),
        .req_data    (req.data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .stat        (stat),
        .rsp_data    (rsp.data)
    );

    a_no_accept_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |-> !stat.clearing)
        else $error("item accepted during memory clear");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("second item accepted while one is in flight");

    a_result_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        is_resp_op(op) |-> (!rsp.valid || rsp.ready))
        else $error("result register overwritten before it was taken");

endmodule
